// File: rtl/core/sha1_pkg.sv
// Shared types, constants and round functions of the SHA-1 hash engine.
// No dependencies; every other file of the engine but sha1_ram imports this package.
package sha1_pkg;

    typedef logic [31:0] t_word;
    typedef logic [6:0]  t_round;
    typedef logic [3:0]  t_waddr;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_ZERO,
        S_LENLO,
        S_RB,
        S_RA,
        S_FOLD,
        S_OUT
    } t_state;

    // Control from the sequencer to the schedule store.
    typedef struct packed {
        logic   load_we;
        t_waddr load_addr;
        t_word  load_data;
        logic   ph_a;
        logic   ph_b;
        t_round rnd;
    } t_sch_ctl;

    // Control from the sequencer to the round datapath.
    typedef struct packed {
        logic   init;
        logic   start;
        logic   step;
        logic   fold;
        t_round rnd;
    } t_rnd_ctl;

    localparam t_word  IV0        = 32'h6745_2301;
    localparam t_word  IV1        = 32'hEFCD_AB89;
    localparam t_word  IV2        = 32'h98BA_DCFE;
    localparam t_word  IV3        = 32'h1032_5476;
    localparam t_word  IV4        = 32'hC3D2_E1F0;
    localparam t_word  K0         = 32'h5A82_7999;
    localparam t_word  K1         = 32'h6ED9_EBA1;
    localparam t_word  K2         = 32'h8F1B_BCDC;
    localparam t_word  K3         = 32'hCA62_C1D6;
    localparam t_word  PAD_WORD   = 32'h8000_0000;
    localparam t_round LAST_ROUND = 7'd79;
    localparam t_waddr LEN_HI_POS = 4'd14;
    localparam t_waddr LAST_POS   = 4'd15;
    localparam logic [2:0] LAST_IDX = 3'd4;
    localparam logic [2:0] FULL_CNT = 3'd4;

    function automatic t_word f_rotl(input t_word x, input int unsigned s);
        f_rotl = (x << s) | (x >> (32 - s));
    endfunction

    function automatic t_word f_round_k(input t_round r);
        if (r < 7'd20) begin
            f_round_k = K0;
        end else if (r < 7'd40) begin
            f_round_k = K1;
        end else if (r < 7'd60) begin
            f_round_k = K2;
        end else begin
            f_round_k = K3;
        end
    endfunction

    function automatic t_word f_round_fn(input t_round r, input t_word b,
                                         input t_word c, input t_word d);
        if (r < 7'd20) begin
            f_round_fn = (b & c) | (~b & d);
        end else if (r >= 7'd40 && r < 7'd60) begin
            f_round_fn = (b & c) | (b & d) | (c & d);
        end else begin
            f_round_fn = b ^ c ^ d;
        end
    endfunction

    // Keeps the valid leading bytes and, for a count below four, appends the 0x80 pad byte after them.
    function automatic t_word f_pad(input t_word data, input logic [2:0] n);
        unique case (n)
            3'd0:    f_pad = PAD_WORD;
            3'd1:    f_pad = {data[31:24], 24'h80_0000};
            3'd2:    f_pad = {data[31:16], 16'h8000};
            3'd3:    f_pad = {data[31:8], 8'h80};
            default: f_pad = data;
        endcase
    endfunction

endpackage

// File: rtl/core/sha1_in_if.sv
// Input channel of the SHA-1 hash engine: valid/ready and one message word.
// Depends on sha1_pkg for the word type.
interface sha1_in_if;
    import sha1_pkg::*;

    logic       valid;
    logic       ready;
    t_word      data_word;
    logic [2:0] byte_count;
    logic       end_of_message;

    modport source (output valid, output data_word, output byte_count,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_word, input byte_count,
                    input end_of_message, output ready);
endinterface

// File: rtl/core/sha1_out_if.sv
// Output channel of the SHA-1 hash engine: valid/ready and one digest word.
// Depends on sha1_pkg for the word type.
interface sha1_out_if;
    import sha1_pkg::*;

    logic       valid;
    logic       ready;
    t_word      digest_word;
    logic [2:0] word_index;
    logic       last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// File: rtl/core/sha1_hash_engine.sv
// Top level of the SHA-1 hash engine: sequencer, padding, length and digest output.
// Uses sha1_pkg, sha1_in_if, sha1_out_if, sha1_sched and sha1_round.
//
//  Channel      Dir  Transaction carries
//  i_in_chan    in   data_word[31:0], byte_count[2:0], end_of_message
//  o_out_chan   out  digest_word[31:0], word_index[2:0], last_word
//
// Message words are taken only while the engine is idle. The sixteenth word of
// a block starts a compression: each of the 80 rounds runs through phase B and
// then phase A, because it needs four schedule words and the mirrored schedule
// RAM delivers two a cycle, and a fold state then adds the working variables
// into the chaining words. The final transaction adds padding words and one or
// two compressions before the five digest words go out, one per accepted cycle.
// Input is refused while a compression, padding or the digest is in progress;
// a stalled output simply holds the current digest word. Reset is synchronous
// and active low, and no clearing pass is needed after it.
module sha1_hash_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sha1_in_if.sink    i_in_chan,
    sha1_out_if.source o_out_chan
);
    import sha1_pkg::*;

    t_state      r_state, n_state;
    t_state      r_ret, n_ret;
    t_waddr      r_cnt, n_cnt;
    logic [60:0] r_len, n_len;
    t_round      r_rnd, n_rnd;
    logic [2:0]  r_oidx, n_oidx;

    logic             w_in_acc;
    logic             w_out_acc;
    logic [2:0]       w_nbytes;
    logic             w_push;
    t_word            w_push_data;
    t_sch_ctl         w_sch;
    t_rnd_ctl         w_rctl;
    t_word            w_w;
    logic [4:0][31:0] w_chain;

    assign w_in_acc  = i_in_chan.valid && i_in_chan.ready;
    assign w_out_acc = o_out_chan.valid && o_out_chan.ready;

    // Byte count of the transaction: four for any word before the end, and a
    // count above four on the final word is taken as four.
    always_comb begin
        if (!i_in_chan.end_of_message || i_in_chan.byte_count[2]) begin
            w_nbytes = FULL_CNT;
        end else begin
            w_nbytes = i_in_chan.byte_count;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (!i_in_chan.end_of_message) begin
                        n_ret = S_IDLE;
                    end else if (w_nbytes == FULL_CNT) begin
                        n_ret = S_PAD80;
                    end else begin
                        n_ret = S_ZERO;
                    end
                    n_state = (r_cnt == LAST_POS) ? S_RB : n_ret;
                end
            end
            S_PAD80: begin
                n_ret   = S_ZERO;
                n_state = (r_cnt == LAST_POS) ? S_RB : S_ZERO;
            end
            S_ZERO: begin
                if (r_cnt == LEN_HI_POS) begin
                    n_state = S_LENLO;
                end else if (r_cnt == LAST_POS) begin
                    n_ret   = S_ZERO;
                    n_state = S_RB;
                end
            end
            S_LENLO: begin
                n_ret   = S_OUT;
                n_state = S_RB;
            end
            S_RB: begin
                n_state = S_RA;
            end
            S_RA: begin
                n_state = (r_rnd == LAST_ROUND) ? S_FOLD : S_RB;
            end
            S_FOLD: begin
                n_state = r_ret;
            end
            S_OUT: begin
                if (w_out_acc && r_oidx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output and datapath control.
    always_comb begin
        w_push      = 1'b0;
        w_push_data = '0;
        w_rctl      = '0;
        w_sch       = '0;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_rnd       = r_rnd;
        n_oidx      = r_oidx;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    w_push = 1'b1;
                    n_len  = r_len + 61'(w_nbytes);
                    if (i_in_chan.end_of_message) begin
                        w_push_data = f_pad(i_in_chan.data_word, w_nbytes);
                    end else begin
                        w_push_data = i_in_chan.data_word;
                    end
                end
            end
            S_PAD80: begin
                w_push      = 1'b1;
                w_push_data = PAD_WORD;
            end
            S_ZERO: begin
                w_push = 1'b1;
                if (r_cnt == LEN_HI_POS) begin
                    w_push_data = r_len[60:29];
                end
            end
            S_LENLO: begin
                w_push      = 1'b1;
                w_push_data = {r_len[28:0], 3'b000};
            end
            S_RB: begin
                w_sch.ph_b = 1'b1;
            end
            S_RA: begin
                w_sch.ph_a  = 1'b1;
                w_rctl.step = 1'b1;
                n_rnd       = (r_rnd == LAST_ROUND) ? '0 : r_rnd + 7'd1;
            end
            S_FOLD: begin
                w_rctl.fold = 1'b1;
            end
            S_OUT: begin
                if (w_out_acc) begin
                    if (r_oidx == LAST_IDX) begin
                        w_rctl.init = 1'b1;
                        n_oidx      = '0;
                        n_cnt       = '0;
                        n_len       = '0;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end
            default: begin
                w_push = 1'b0;
            end
        endcase

        // A word written into the last slot completes the block, so the
        // working variables are loaded from the chaining words at once.
        if (w_push) begin
            n_cnt        = r_cnt + 4'd1;
            w_rctl.start = (r_cnt == LAST_POS);
        end
        w_sch.load_we   = w_push;
        w_sch.load_addr = r_cnt;
        w_sch.load_data = w_push_data;
        w_sch.rnd       = r_rnd;
        w_rctl.rnd      = r_rnd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_cnt   <= '0;
            r_len   <= '0;
            r_rnd   <= '0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_rnd   <= n_rnd;
            r_oidx  <= n_oidx;
        end
    end

    sha1_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (w_sch),
        .o_w   (w_w)
    );

    sha1_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_rctl),
        .i_w     (w_w),
        .o_chain (w_chain)
    );

    assign i_in_chan.ready        = (r_state == S_IDLE);
    assign o_out_chan.valid       = (r_state == S_OUT);
    assign o_out_chan.digest_word = w_chain[r_oidx];
    assign o_out_chan.word_index  = r_oidx;
    assign o_out_chan.last_word   = (r_oidx == LAST_IDX);
endmodule

// File: rtl/core/sha1_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sha1_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/sha1_sched.sv
// Message schedule store: two mirrored RAMs give two reads a cycle over the
// sixteen-word window, and the expanded word is formed here. Uses sha1_pkg, sha1_ram.
module sha1_sched (
    input  logic               i_clk,
    input  sha1_pkg::t_sch_ctl i_ctl,
    output sha1_pkg::t_word    o_w
);
    import sha1_pkg::*;

    t_waddr w_raddr0;
    t_waddr w_raddr1;
    t_waddr w_rnd_lo;
    logic   w_we;
    t_waddr w_waddr;
    t_word  w_wdata;
    t_word  w_rd0;
    t_word  w_rd1;
    t_word  w_w;
    t_word  r_w16;
    t_word  r_x;

    assign w_rnd_lo = i_ctl.rnd[3:0];

    // Phase B fetches W[t-8] and W[t-3]; phase A starts the first pair of the next
    // round, W[t-16] and W[t-14], which other states fetch for the current round.
    always_comb begin
        if (i_ctl.ph_b) begin
            w_raddr0 = w_rnd_lo + 4'd8;
            w_raddr1 = w_rnd_lo + 4'd13;
        end else if (i_ctl.ph_a) begin
            w_raddr0 = w_rnd_lo + 4'd1;
            w_raddr1 = w_rnd_lo + 4'd3;
        end else begin
            w_raddr0 = w_rnd_lo;
            w_raddr1 = w_rnd_lo + 4'd2;
        end
    end

    always_comb begin
        if (i_ctl.rnd < 7'd16) begin
            w_w = r_w16;
        end else begin
            w_w = f_rotl(r_x ^ w_rd0 ^ w_rd1, 1);
        end
    end

    always_comb begin
        if (i_ctl.ph_a && i_ctl.rnd >= 7'd16) begin
            w_we    = 1'b1;
            w_waddr = w_rnd_lo;
            w_wdata = w_w;
        end else begin
            w_we    = i_ctl.load_we;
            w_waddr = i_ctl.load_addr;
            w_wdata = i_ctl.load_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ph_b) begin
            r_w16 <= w_rd0;
            r_x   <= w_rd0 ^ w_rd1;
        end
    end

    sha1_ram #(.WIDTH(32), .DEPTH(16)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr0),
        .o_rdata (w_rd0)
    );

    sha1_ram #(.WIDTH(32), .DEPTH(16)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr1),
        .o_rdata (w_rd1)
    );

    assign o_w = w_w;
endmodule

// File: rtl/core/sha1_round.sv
// Round datapath: working variables a to e, the chaining words and the fold.
// Uses sha1_pkg.
module sha1_round (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1_pkg::t_rnd_ctl i_ctl,
    input  sha1_pkg::t_word    i_w,
    output logic [4:0][31:0]   o_chain
);
    import sha1_pkg::*;

    t_word r_a, r_b, r_c, r_d, r_e;
    t_word r_h0, r_h1, r_h2, r_h3, r_h4;
    t_word w_t;

    assign w_t = f_rotl(r_a, 5) + f_round_fn(i_ctl.rnd, r_b, r_c, r_d) + r_e
               + f_round_k(i_ctl.rnd) + i_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_a  <= '0;
            r_b  <= '0;
            r_c  <= '0;
            r_d  <= '0;
            r_e  <= '0;
            r_h0 <= IV0;
            r_h1 <= IV1;
            r_h2 <= IV2;
            r_h3 <= IV3;
            r_h4 <= IV4;
        end else if (i_ctl.start) begin
            r_a <= r_h0;
            r_b <= r_h1;
            r_c <= r_h2;
            r_d <= r_h3;
            r_e <= r_h4;
        end else if (i_ctl.step) begin
            r_a <= w_t;
            r_b <= r_a;
            r_c <= f_rotl(r_b, 30);
            r_d <= r_c;
            r_e <= r_d;
        end else if (i_ctl.fold) begin
            r_h0 <= r_h0 + r_a;
            r_h1 <= r_h1 + r_b;
            r_h2 <= r_h2 + r_c;
            r_h3 <= r_h3 + r_d;
            r_h4 <= r_h4 + r_e;
        end
    end

    assign o_chain = {r_h4, r_h3, r_h2, r_h1, r_h0};
endmodule

// File: tb/testbench.sv
// Self-checking testbench for the streaming SHA-1 hash engine (sha1_hash_engine).
// Depends on sha1_pkg, sha1_in_if, sha1_out_if and sha1_hash_engine from the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1_pkg::*;

    // Known digests of the empty message and of "abc", h0 in the top bits.
    localparam logic [159:0] EMPTY_DIGEST =
        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] ABC_DIGEST =
        160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

    localparam int RANDOM_ITEMS    = 255;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 400;
    localparam int DIRECTED_ROWS   = 15;

    // One digest word as it should leave the engine.
    typedef struct packed {
        t_word      digest;
        logic [2:0] index;
        logic       last;
    } t_digest_beat;

    // One row of the directed stimulus. Where known is set, the digest that the
    // row completes is typed in; otherwise the hash model supplies it.
    typedef struct packed {
        t_word        data;
        logic [2:0]   count;
        logic         eom;
        logic         known;
        logic [159:0] digest;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    sha1_in_if  in_chan ();
    sha1_out_if out_chan ();

    sha1_hash_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_chan),
        .o_out_chan (out_chan)
    );

    // State of the hash model: chaining words, the block being filled and the
    // running byte length, which wraps at 2^61 just as the engine's does.
    t_word        chain_q [5];
    t_word        block_q [16];
    logic [3:0]   block_fill_q;
    logic [60:0]  msg_len_q;
    t_word        digest_words [5];

    t_digest_beat digest_beats_due [$];
    t_stim_row    directed_rows [DIRECTED_ROWS];

    int  fail_count;
    int  items_sent;
    int  beats_taken;
    int  idle_cycles;
    bit  quiet_send;
    bit  quiet_recv;

    // The clock runs freely from time zero.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Restores the hash model to the state of a fresh message.
    function automatic void hash_restart();
        chain_q[0]   = IV0;
        chain_q[1]   = IV1;
        chain_q[2]   = IV2;
        chain_q[3]   = IV3;
        chain_q[4]   = IV4;
        block_fill_q = '0;
        msg_len_q    = '0;
        foreach (block_q[i]) block_q[i] = '0;
    endfunction

    // Runs the 80 rounds over the sixteen words now held in the block and adds
    // the result into the chaining words.
    function automatic void hash_fold_block();
        t_word a, b, c, d, e, f, k, w, t;
        a = chain_q[0];
        b = chain_q[1];
        c = chain_q[2];
        d = chain_q[3];
        e = chain_q[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 16) begin
                w = block_q[r];
            end else begin
                w = block_q[(r - 3) % 16] ^ block_q[(r - 8) % 16]
                  ^ block_q[(r - 14) % 16] ^ block_q[r % 16];
                w = {w[30:0], w[31]};
                block_q[r % 16] = w;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_q[0] += a;
        chain_q[1] += b;
        chain_q[2] += c;
        chain_q[3] += d;
        chain_q[4] += e;
    endfunction

    function automatic void hash_absorb(input t_word w);
        block_q[block_fill_q] = w;
        block_fill_q++;
        if (block_fill_q == '0) begin
            hash_fold_block();
        end
    endfunction

    // Takes one accepted transaction into the model. Returns 1 when it closes a
    // message, with the digest left in digest_words.
    function automatic bit hash_take_item(input t_word data, input logic [2:0] count,
                                          input logic eom);
        logic [2:0]  n;
        t_word       keep;
        logic [63:0] bit_len;
        if (!eom) begin
            // Before the end every word counts as four bytes, whatever its count.
            msg_len_q += 61'd4;
            hash_absorb(data);
            return 1'b0;
        end
        n = (count > FULL_CNT) ? FULL_CNT : count;
        msg_len_q += 61'(n);
        if (n == FULL_CNT) begin
            hash_absorb(data);
            hash_absorb(PAD_WORD);
        end else begin
            // Bytes past the count are dropped and the pad byte follows the last one.
            keep = (n == 3'd0) ? '0 : ~32'h0 << (32 - 8 * n);
            hash_absorb((data & keep) | (PAD_WORD >> (8 * n)));
        end
        while (block_fill_q != LEN_HI_POS) begin
            hash_absorb('0);
        end
        bit_len = {msg_len_q, 3'b000};
        hash_absorb(bit_len[63:32]);
        hash_absorb(bit_len[31:0]);
        foreach (digest_words[i]) digest_words[i] = chain_q[i];
        hash_restart();
        return 1'b1;
    endfunction

    // Offers one transaction, after a random pause unless quiet_send is set, and
    // waits for the engine to take it. The task starts and ends on a falling edge,
    // so valid is never lowered and raised again within one time step.
    task automatic send_word(input t_word data, input logic [2:0] count, input logic eom,
                             input logic known, input logic [159:0] digest);
        int           pause;
        t_digest_beat beat;
        pause = quiet_send ? 0 : $urandom_range(0, 10);
        if (pause > 0) begin
            in_chan.valid <= 1'b0;
            repeat (pause) @(negedge i_clk);
        end
        in_chan.valid          <= 1'b1;
        in_chan.data_word      <= data;
        in_chan.byte_count     <= count;
        in_chan.end_of_message <= eom;
        do @(posedge i_clk); while (!in_chan.ready);
        items_sent++;
        if (hash_take_item(data, count, eom)) begin
            for (int i = 0; i < 5; i++) begin
                beat.digest = known ? digest[159 - 32 * i -: 32] : digest_words[i];
                beat.index  = 3'(i);
                beat.last   = (3'(i) == LAST_IDX);
                digest_beats_due.push_back(beat);
            end
        end
        @(negedge i_clk);
    endtask

    // Main stimulus: reset, the directed table, then random messages.
    initial begin
        int          body_len;
        logic [2:0]  count;
        fail_count  = 0;
        items_sent  = 0;
        quiet_send  = 1'b0;
        hash_restart();
        i_rst_n                = 1'b0;
        in_chan.valid          = 1'b0;
        in_chan.data_word      = '0;
        in_chan.byte_count     = '0;
        in_chan.end_of_message = 1'b0;

        directed_rows = '{
            // Empty message, then again with all data bits set but a count of zero.
            '{32'h0000_0000, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
            '{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
            // "abc" with a junk byte past the count, which must be ignored.
            '{32'h6162_63A5, 3'd3, 1'b1, 1'b1, ABC_DIGEST},
            // Final count above four counts as four.
            '{32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, 160'h0},
            '{32'h0000_0000, 3'd4, 1'b1, 1'b0, 160'h0},
            // A short count before the end still takes all four bytes.
            '{32'h6162_6364, 3'd1, 1'b0, 1'b0, 160'h0},
            '{32'h0000_0000, 3'd0, 1'b1, 1'b0, 160'h0},
            '{32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 160'h0},
            '{32'h0000_0000, 3'd5, 1'b0, 1'b0, 160'h0},
            '{32'h8000_0001, 3'd7, 1'b0, 1'b0, 160'h0},
            '{32'h1234_5678, 3'd1, 1'b1, 1'b0, 160'h0},
            '{32'hDEAD_BEEF, 3'd2, 1'b1, 1'b0, 160'h0},
            '{32'h0000_FFFF, 3'd3, 1'b1, 1'b0, 160'h0},
            '{32'hA5A5_5A5A, 3'd5, 1'b1, 1'b0, 160'h0},
            '{32'h5A5A_A5A5, 3'd6, 1'b1, 1'b0, 160'h0}
        };

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            send_word(directed_rows[r].data, directed_rows[r].count, directed_rows[r].eom,
                      directed_rows[r].known, directed_rows[r].digest);
        end

        // Random messages. Half are short, a good share sit on the lengths where
        // the padding and the length words spill into a second block, and a few
        // span several blocks. Each message is sent whole.
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: body_len = $urandom_range(0, 6);
                5, 6, 7:       body_len = 13 + $urandom_range(0, 3)
                                        + 16 * $urandom_range(0, 1);
                default:       body_len = $urandom_range(17, 40);
            endcase
            quiet_send = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < body_len; i++) begin
                count = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : FULL_CNT;
                send_word($urandom, count, 1'b0, 1'b0, 160'h0);
            end
            send_word($urandom, 3'($urandom_range(0, 7)), 1'b1, 1'b0, 160'h0);
        end
        in_chan.valid <= 1'b0;

        // Drain: every digest must come out, then the engine should stay quiet.
        while (digest_beats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Receiver: a random stall before each digest word, quiet stretches now and
    // then, and one long hold-off after three digests so that the engine fills
    // up and refuses input while the sender keeps offering.
    initial begin
        int  stall;
        bit  held;
        beats_taken    = 0;
        held           = 1'b0;
        quiet_recv     = 1'b0;
        out_chan.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (beats_taken % 5 == 0) begin
                quiet_recv = ($urandom_range(0, 2) == 0);
            end
            if (beats_taken == 15 && !held) begin
                stall = HOLD_OFF_CYCLES;
                held  = 1'b1;
            end else begin
                stall = quiet_recv ? 0 : $urandom_range(0, 10);
            end
            if (stall > 0) begin
                out_chan.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_chan.ready <= 1'b1;
            do @(posedge i_clk); while (!out_chan.valid);
            beats_taken++;
            @(negedge i_clk);
        end
    end

    // Checker: every accepted digest word is compared with the oldest one due.
    initial begin
        t_digest_beat due;
        forever begin
            @(posedge i_clk);
            if (out_chan.valid && out_chan.ready) begin
                if (digest_beats_due.size() == 0) begin
                    $display("%0t: unexpected digest transaction, word %h index %0d last %b",
                             $time, out_chan.digest_word, out_chan.word_index,
                             out_chan.last_word);
                    fail_count++;
                end else begin
                    due = digest_beats_due.pop_front();
                    if (out_chan.digest_word !== due.digest) begin
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, due.digest, out_chan.digest_word);
                        fail_count++;
                    end
                    if (out_chan.word_index !== due.index) begin
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, due.index, out_chan.word_index);
                        fail_count++;
                    end
                    if (out_chan.last_word !== due.last) begin
                        $display("%0t: last_word expected %b actual %b",
                                 $time, due.last, out_chan.last_word);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel completes a transaction for too
    // long. The limit covers the long hold-off as well as the worst final word,
    // which pads, compresses twice and then waits on a stalled receiver.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

endmodule
